### rtl/core/ffss_pkg.sv
package ffss_pkg;

	// field widths fixed by the request and result formats
	localparam int ADDR_W = 16;
	localparam int SLOT_W = 11;
	localparam int DIST_W = 8;
	localparam int TYPE_W = 2;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 6;
	// slot arithmetic needs one bit of headroom for end + 1
	localparam int CAND_W = SLOT_W + 1;

	localparam int MAX_NODES_DEF = 32;
	localparam int MAX_SLOTS_DEF = 1024;
	localparam logic [SLOT_W-1:0] TOTAL_RESET = SLOT_W'(1024);

	typedef enum logic [TYPE_W-1:0] {
		REQ_SCHED,
		REQ_REMOVE,
		REQ_SETDIST,
		REQ_CLEAR
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE,
		ST_NOGAP,
		ST_FULL,
		ST_NOTFOUND
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SHUP,
		S_INSERT,
		S_FIND,
		S_SHDN,
		S_FIN_RD,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_INC,
		IDX_DEC,
		IDX_CNT
	} idx_op_t;

	typedef enum logic [2:0] {
		RD_IDX,
		RD_IDX_P1,
		RD_IDX_M1,
		RD_IDX_P2,
		RD_LAST
	} rd_op_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_SHUP,
		WR_SHDN,
		WR_NEW,
		WR_DIST
	} wr_op_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_CLEAR,
		CNT_INSERT,
		CNT_REMOVE,
		CNT_SETDIST
	} cnt_op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SLOT_W-1:0] start;
		logic [SLOT_W-1:0] demand;
		logic [DIST_W-1:0] dist_cnt;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic    in_ready;
		logic    load_req;
		idx_op_t idx_op;
		rd_op_t  rd_op;
		wr_op_t  wr_op;
		cnt_op_t cnt_op;
		logic    cand_adv;
		logic    fit_save;
		logic    st_set;
		status_t st_val;
		logic    res_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic      req_valid;
		req_type_t req_type;
		logic      full;
		logic      bad_dem;
		logic      fit;
		logic      hit;
		logic      more;
		logic      above_pos;
		logic      out_free;
	} sts_t;

endpackage

### rtl/core/ffss_req_if.sv
interface ffss_req_if;
	logic                          valid;
	logic                          ready;
	logic [ffss_pkg::TYPE_W-1:0]   req_type;
	logic [ffss_pkg::ADDR_W-1:0]   node_addr;
	logic [ffss_pkg::SLOT_W-1:0]   slot_demand;
	logic [ffss_pkg::DIST_W-1:0]   dist_count;

	modport source (
		output valid, req_type, node_addr, slot_demand, dist_count,
		input  ready
	);
	modport sink (
		input  valid, req_type, node_addr, slot_demand, dist_count,
		output ready
	);
endinterface

### rtl/core/ffss_res_if.sv
interface ffss_res_if;
	logic                          valid;
	logic                          ready;
	logic [ffss_pkg::STAT_W-1:0]   status;
	logic [ffss_pkg::SLOT_W-1:0]   assigned_start;
	logic [ffss_pkg::CNT_W-1:0]    node_count;
	logic [ffss_pkg::SLOT_W-1:0]   assigned_slots;
	logic [ffss_pkg::CNT_W-1:0]    pending_dist_nodes;
	logic [ffss_pkg::SLOT_W-1:0]   last_slot;

	modport source (
		output valid, status, assigned_start, node_count, assigned_slots,
		       pending_dist_nodes, last_slot,
		input  ready
	);
	modport sink (
		input  valid, status, assigned_start, node_count, assigned_slots,
		       pending_dist_nodes, last_slot,
		output ready
	);
endinterface

### rtl/core/ffss_ctrl.sv
module ffss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  ffss_pkg::sts_t  sts,
	output ffss_pkg::cmd_t  cmd
);

	ffss_pkg::state_t state_q, state_d;
	logic             wpend_q, wpend_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffss_pkg::S_IDLE;
			wpend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wpend_q <= wpend_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		wpend_d      = wpend_q;
		cmd.in_ready = 1'b0;
		cmd.load_req = 1'b0;
		cmd.idx_op   = ffss_pkg::IDX_HOLD;
		cmd.rd_op    = ffss_pkg::RD_IDX;
		cmd.wr_op    = ffss_pkg::WR_NONE;
		cmd.cnt_op   = ffss_pkg::CNT_HOLD;
		cmd.cand_adv = 1'b0;
		cmd.fit_save = 1'b0;
		cmd.st_set   = 1'b0;
		cmd.st_val   = ffss_pkg::ST_DONE;
		cmd.res_load = 1'b0;
		case (state_q)
			ffss_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ffss_pkg::S_CHECK;
				end
			end
			// early outcomes, otherwise start the walk at entry zero
			ffss_pkg::S_CHECK: begin
				cmd.rd_op = ffss_pkg::RD_IDX;
				case (sts.req_type)
					ffss_pkg::REQ_CLEAR: begin
						cmd.cnt_op = ffss_pkg::CNT_CLEAR;
						state_d    = ffss_pkg::S_FIN_RD;
					end
					ffss_pkg::REQ_SCHED: begin
						if (sts.full) begin
							cmd.st_set = 1'b1;
							cmd.st_val = ffss_pkg::ST_FULL;
							state_d    = ffss_pkg::S_FIN_RD;
						end else if (sts.bad_dem) begin
							cmd.st_set = 1'b1;
							cmd.st_val = ffss_pkg::ST_NOGAP;
							state_d    = ffss_pkg::S_FIN_RD;
						end else begin
							state_d = ffss_pkg::S_SCAN;
						end
					end
					default: begin
						state_d = ffss_pkg::S_FIND;
					end
				endcase
			end
			// first-fit gap search, one entry per cycle
			ffss_pkg::S_SCAN: begin
				if (sts.fit) begin
					cmd.fit_save = 1'b1;
					cmd.idx_op   = ffss_pkg::IDX_CNT;
					wpend_d      = 1'b0;
					state_d      = ffss_pkg::S_SHUP;
				end else if (sts.more) begin
					cmd.cand_adv = 1'b1;
					cmd.idx_op   = ffss_pkg::IDX_INC;
					cmd.rd_op    = ffss_pkg::RD_IDX_P1;
				end else begin
					cmd.st_set = 1'b1;
					cmd.st_val = ffss_pkg::ST_NOGAP;
					state_d    = ffss_pkg::S_FIN_RD;
				end
			end
			// move entries up one place, read and write overlapped
			ffss_pkg::S_SHUP: begin
				if (wpend_q) begin
					cmd.wr_op = ffss_pkg::WR_SHUP;
				end
				if (sts.above_pos) begin
					cmd.rd_op  = ffss_pkg::RD_IDX_M1;
					cmd.idx_op = ffss_pkg::IDX_DEC;
					wpend_d    = 1'b1;
				end else begin
					wpend_d = 1'b0;
					state_d = ffss_pkg::S_INSERT;
				end
			end
			ffss_pkg::S_INSERT: begin
				cmd.wr_op  = ffss_pkg::WR_NEW;
				cmd.cnt_op = ffss_pkg::CNT_INSERT;
				cmd.st_set = 1'b1;
				cmd.st_val = ffss_pkg::ST_DONE;
				state_d    = ffss_pkg::S_FIN_RD;
			end
			// address lookup for remove and set-dist
			ffss_pkg::S_FIND: begin
				cmd.rd_op = ffss_pkg::RD_IDX_P1;
				if (sts.hit) begin
					cmd.st_set = 1'b1;
					cmd.st_val = ffss_pkg::ST_DONE;
					if (sts.req_type == ffss_pkg::REQ_REMOVE) begin
						cmd.cnt_op = ffss_pkg::CNT_REMOVE;
						state_d    = ffss_pkg::S_SHDN;
					end else begin
						cmd.wr_op  = ffss_pkg::WR_DIST;
						cmd.cnt_op = ffss_pkg::CNT_SETDIST;
						state_d    = ffss_pkg::S_FIN_RD;
					end
				end else if (sts.more) begin
					cmd.idx_op = ffss_pkg::IDX_INC;
				end else begin
					cmd.st_set = 1'b1;
					cmd.st_val = ffss_pkg::ST_NOTFOUND;
					state_d    = ffss_pkg::S_FIN_RD;
				end
			end
			// close the hole left by a removed entry
			ffss_pkg::S_SHDN: begin
				if (sts.more) begin
					cmd.wr_op  = ffss_pkg::WR_SHDN;
					cmd.rd_op  = ffss_pkg::RD_IDX_P2;
					cmd.idx_op = ffss_pkg::IDX_INC;
				end else begin
					state_d = ffss_pkg::S_FIN_RD;
				end
			end
			// fetch the highest entry for the last slot
			ffss_pkg::S_FIN_RD: begin
				cmd.rd_op = ffss_pkg::RD_LAST;
				state_d   = ffss_pkg::S_FIN;
			end
			ffss_pkg::S_FIN: begin
				cmd.rd_op = ffss_pkg::RD_LAST;
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ffss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffss_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/ffss_dp.sv
module ffss_dp #(
	parameter int MAX_NODES = ffss_pkg::MAX_NODES_DEF,
	parameter int MAX_SLOTS = ffss_pkg::MAX_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ffss_req_if.sink                      req,
	ffss_res_if.source                    res,
	input  logic                          total_slots_we,
	input  logic [ffss_pkg::SLOT_W-1:0]   total_slots,
	input  ffss_pkg::cmd_t                cmd,
	output ffss_pkg::sts_t                sts
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int XW = CW + 1;
	localparam int SW = ffss_pkg::SLOT_W;
	localparam int KW = ffss_pkg::CAND_W;
	localparam logic [SW-1:0] SLOT_CAP = SW'(MAX_SLOTS);

	// entry table, one read and one write port
	ffss_pkg::entry_t mem_q [MAX_NODES];
	ffss_pkg::entry_t rd_q;

	ffss_pkg::req_type_t            type_q;
	logic [ffss_pkg::ADDR_W-1:0]    addr_q;
	logic [SW-1:0]                  dem_q;
	logic [ffss_pkg::DIST_W-1:0]    dist_q;
	logic [SW-1:0]                  total_q;
	logic [CW-1:0]                  idx_q, pos_q, cnt_q, pend_q;
	logic [SW-1:0]                  sum_q, start_q;
	logic [KW-1:0]                  cand_q;
	ffss_pkg::status_t              status_q;

	logic                           res_valid_q;
	ffss_pkg::status_t              res_status_q;
	logic [SW-1:0]                  res_start_q, res_sum_q, res_last_q;
	logic [ffss_pkg::CNT_W-1:0]     res_count_q, res_pend_q;

	logic [XW-1:0]                  idx_p1, idx_p2, idx_m1, cnt_m1;
	logic [AW-1:0]                  rd_addr, wr_addr;
	logic                           wr_en;
	ffss_pkg::entry_t               wr_data;
	logic [SW-1:0]                  total_use;
	logic [KW-1:0]                  next_slot, end_p1;
	logic [KW:0]                    new_last;
	logic [SW-1:0]                  last_slot;
	logic                           more;

	assign idx_p1 = XW'(idx_q) + XW'(1);
	assign idx_p2 = XW'(idx_q) + XW'(2);
	assign idx_m1 = XW'(idx_q) - XW'(1);
	assign cnt_m1 = XW'(cnt_q) - XW'(1);

	// slot limit in use
	assign total_use = (32'(total_q) > MAX_SLOTS) ? SLOT_CAP : total_q;

	// gap test against the entry under the walk
	assign more      = idx_q < cnt_q;
	assign next_slot = more ? KW'(rd_q.start) : KW'(total_use) + KW'(1);
	assign end_p1    = KW'(rd_q.start) + KW'(rd_q.demand);
	assign new_last  = (KW+1)'(cand_q) + (KW+1)'(dem_q) - (KW+1)'(1);
	assign last_slot = rd_q.start + rd_q.demand - SW'(1);

	always_comb begin
		sts.req_valid = req.valid;
		sts.req_type  = type_q;
		sts.full      = cnt_q >= CW'(MAX_NODES);
		sts.bad_dem   = (dem_q == '0) || (dem_q > total_use);
		sts.fit       = (next_slot > cand_q) && ((next_slot - cand_q) >= KW'(dem_q))
		                && (new_last <= (KW+1)'(total_use));
		sts.hit       = more && (rd_q.addr == addr_q);
		sts.more      = more;
		sts.above_pos = idx_q > pos_q;
		sts.out_free  = !res_valid_q || res.ready;
	end

	assign req.ready = cmd.in_ready;

	// read address select
	always_comb begin
		case (cmd.rd_op)
			ffss_pkg::RD_IDX:    rd_addr = idx_q[AW-1:0];
			ffss_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
			ffss_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
			ffss_pkg::RD_IDX_P2: rd_addr = idx_p2[AW-1:0];
			ffss_pkg::RD_LAST:   rd_addr = cnt_m1[AW-1:0];
			default:             rd_addr = idx_q[AW-1:0];
		endcase
	end

	// write port select
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		case (cmd.wr_op)
			ffss_pkg::WR_SHUP: begin
				wr_addr = idx_p1[AW-1:0];
			end
			ffss_pkg::WR_SHDN: begin
				wr_addr = idx_q[AW-1:0];
			end
			ffss_pkg::WR_NEW: begin
				wr_addr = pos_q[AW-1:0];
				wr_data = '{addr: addr_q, start: start_q, demand: dem_q, dist_cnt: dist_q};
			end
			ffss_pkg::WR_DIST: begin
				wr_data.dist_cnt = dist_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// table storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// request fields, walk pointers and gap candidate
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q  <= ffss_pkg::req_type_t'(req.req_type);
			addr_q  <= req.node_addr;
			dem_q   <= req.slot_demand;
			dist_q  <= req.dist_count;
			idx_q   <= '0;
			cand_q  <= KW'(1);
			start_q <= '0;
		end else begin
			case (cmd.idx_op)
				ffss_pkg::IDX_INC: idx_q <= idx_p1[CW-1:0];
				ffss_pkg::IDX_DEC: idx_q <= idx_m1[CW-1:0];
				ffss_pkg::IDX_CNT: idx_q <= cnt_q;
				default:           idx_q <= idx_q;
			endcase
			if (cmd.cand_adv) begin
				cand_q <= end_p1;
			end
			if (cmd.fit_save) begin
				pos_q   <= idx_q;
				start_q <= SW'(cand_q);
			end
		end
		if (cmd.load_req) begin
			status_q <= ffss_pkg::ST_DONE;
		end else if (cmd.st_set) begin
			status_q <= cmd.st_val;
		end
	end

	// table summary counters and the slot limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			pend_q  <= '0;
			total_q <= ffss_pkg::TOTAL_RESET;
		end else begin
			if (total_slots_we) begin
				total_q <= total_slots;
			end
			case (cmd.cnt_op)
				ffss_pkg::CNT_CLEAR: begin
					cnt_q  <= '0;
					sum_q  <= '0;
					pend_q <= '0;
				end
				ffss_pkg::CNT_INSERT: begin
					cnt_q <= cnt_q + CW'(1);
					sum_q <= sum_q + dem_q;
					if (dist_q != '0) begin
						pend_q <= pend_q + CW'(1);
					end
				end
				ffss_pkg::CNT_REMOVE: begin
					cnt_q <= cnt_q - CW'(1);
					sum_q <= sum_q - rd_q.demand;
					if (rd_q.dist_cnt != '0) begin
						pend_q <= pend_q - CW'(1);
					end
				end
				ffss_pkg::CNT_SETDIST: begin
					if ((rd_q.dist_cnt != '0) && (dist_q == '0)) begin
						pend_q <= pend_q - CW'(1);
					end else if ((rd_q.dist_cnt == '0) && (dist_q != '0)) begin
						pend_q <= pend_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= status_q;
			res_start_q  <= start_q;
			res_count_q  <= ffss_pkg::CNT_W'(cnt_q);
			res_sum_q    <= sum_q;
			res_pend_q   <= ffss_pkg::CNT_W'(pend_q);
			res_last_q   <= (cnt_q == '0) ? '0 : last_slot;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.status             = res_status_q;
	assign res.assigned_start     = res_start_q;
	assign res.node_count         = res_count_q;
	assign res.assigned_slots     = res_sum_q;
	assign res.pending_dist_nodes = res_pend_q;
	assign res.last_slot          = res_last_q;

endmodule

### rtl/core/first_fit_slot_scheduler_core.sv
// First-fit slot scheduler.
// req channel: one request per transfer (schedule, remove, set distribution
// count, clear). res channel: exactly one result per request, in order,
// with status, assigned start and the table summary.
// total_slots is written with total_slots_we; the user must do so only while
// no request is in flight; the block itself does not enforce this. A request
// is taken only when the block is idle; it then walks the sorted entry table
// through a single read port, one entry per cycle. Clear, table full and bad
// demand finish without a walk. Remove and set-dist search the table by
// address, and a remove then shifts the later entries down; a schedule
// searches for a gap and then shifts entries up to insert the new one.
// The result sits in an output register; a new request is accepted while it
// waits. When the receiver stalls, the following result waits in the block
// and no further request is taken until it moves into the output register.
// Reset clears the table, the counters and the output valid and sets the
// slot limit to 1024; the entry storage itself is not cleared.
module first_fit_slot_scheduler_core #(
	parameter int MAX_NODES = ffss_pkg::MAX_NODES_DEF,
	parameter int MAX_SLOTS = ffss_pkg::MAX_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ffss_req_if.sink                      req,
	ffss_res_if.source                    res,
	input  logic                          total_slots_we,
	input  logic [ffss_pkg::SLOT_W-1:0]   total_slots
);

	ffss_pkg::cmd_t cmd;
	ffss_pkg::sts_t sts;

	// sequencer
	ffss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// table, counters and result register
	ffss_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.res            (res),
		.total_slots_we (total_slots_we),
		.total_slots    (total_slots),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule
